// ===== hw/rtl/rsa64_pkg.sv =====
`timescale 1ns / 1ps

package rsa64_pkg;

   localparam int KEY_BITS_DEFAULT = 64;
   localparam int DATA_WIDTH       = 64;
   localparam int CSR_INDEX_WIDTH  = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODULUS          = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PUBLIC_EXPONENT  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRIVATE_EXPONENT = 2'd2;

   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   localparam logic [7:0] PAD_MARK = 8'h02;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SQUARE,
      ST_MULT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
   } mm_ctrl_type;

endpackage

// ===== hw/rtl/rsa64_if.sv =====
`timescale 1ns / 1ps

interface rsa64_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [7:0]  message_byte;
   logic [31:0] pad_random;
   logic [63:0] cipher_in;
   modport source (output valid, command, message_byte, pad_random, cipher_in, input ready);
   modport sink   (input valid, command, message_byte, pad_random, cipher_in, output ready);
endinterface

interface rsa64_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] cipher_out;
   logic [7:0]  plain_byte;
   logic        modulus_error;
   modport source (output valid, cipher_out, plain_byte, modulus_error, input ready);
   modport sink   (input valid, cipher_out, plain_byte, modulus_error, output ready);
endinterface

interface rsa64_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/rsa64_byte_encrypt_decrypt.sv =====
`timescale 1ns / 1ps
// Work per beat: (KEY_BITS + 1 + set exponent bits) modular multiplies between the
// accepting edge and result valid.
// Each multiply has an issue step, a bit-serial pass over the 64 bits of b and a completion
// step; the first multiply reduces the base. A modulus below 2 answers in the cycle after the beat.
// Throughput: one beat at a time; the next beat is taken after the result has left.
// Reset clears the three key registers to zero and returns control to idle.
module rsa64_byte_encrypt_decrypt #(
   parameter int KEY_BITS = rsa64_pkg::KEY_BITS_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   rsa64_req_if.sink   req,
   rsa64_rsp_if.source rsp,
   rsa64_csr_if.sink   csr
);
   // Key registers.
   logic [KEY_BITS-1:0] modulus_ff, pub_ff, priv_ff;

   // Control: busy while an item is in flight, rsp_valid holds the result.
   logic busy_ff, busy_in;
   logic out_valid_ff, out_valid_in;
   logic cmd_ff;
   logic [63:0] cipher_ff, cipher_in;
   logic [7:0]  plain_ff, plain_in;
   logic        err_ff, err_in;

   logic                go, done;
   logic [KEY_BITS-1:0] expo, value;
   logic [63:0]         word, base;
   logic                small_mod;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= '0;
         pub_ff     <= '0;
         priv_ff    <= '0;
      end else if (csr.valid) begin
         case (csr.index)
            rsa64_pkg::CSR_MODULUS:          modulus_ff <= csr.data[KEY_BITS-1:0];
            rsa64_pkg::CSR_PUBLIC_EXPONENT:  pub_ff     <= csr.data[KEY_BITS-1:0];
            rsa64_pkg::CSR_PRIVATE_EXPONENT: priv_ff    <= csr.data[KEY_BITS-1:0];
            default: ;
         endcase
      end
   end

   // A beat is taken only when nothing is in flight and the output is free.
   assign req.ready = !busy_ff && !out_valid_ff;
   assign small_mod = (modulus_ff < KEY_BITS'(2));

   // Padded word: byte, pad at bit 16, marker at bit 48. It keeps its full width
   // and is reduced modulo the key-width modulus; a ciphertext is cut to the key width.
   assign word = {8'h00, rsa64_pkg::PAD_MARK, req.pad_random, 8'h00, req.message_byte};
   assign base = (req.command == rsa64_pkg::CMD_ENCRYPT) ? word
                                                         : 64'(req.cipher_in[KEY_BITS-1:0]);
   assign expo = (req.command == rsa64_pkg::CMD_ENCRYPT) ? pub_ff : priv_ff;
   assign go   = req.valid && req.ready && !small_mod;

   rsa64_seq #(.KEY_BITS(KEY_BITS)) u_seq (
      .clock(clock), .reset(reset), .go(go), .base(base), .expo(expo),
      .m(modulus_ff), .done(done), .value(value)
   );

   always_comb begin
      busy_in      = busy_ff;
      out_valid_in = out_valid_ff;
      cipher_in    = cipher_ff;
      plain_in     = plain_ff;
      err_in       = err_ff;
      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end
      if (req.valid && req.ready) begin
         if (small_mod) begin
            // No exponentiation: flag the error straight away.
            out_valid_in = 1'b1;
            cipher_in    = '0;
            plain_in     = '0;
            err_in       = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end
      if (done) begin
         busy_in      = 1'b0;
         out_valid_in = 1'b1;
         err_in       = 1'b0;
         if (cmd_ff == rsa64_pkg::CMD_ENCRYPT) begin
            cipher_in = 64'(value);
            plain_in  = '0;
         end else begin
            cipher_in = '0;
            plain_in  = value[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      cipher_ff <= cipher_in;
      plain_ff  <= plain_in;
      err_ff    <= err_in;
      if (req.valid && req.ready) begin
         cmd_ff <= req.command;
      end
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.cipher_out    = cipher_ff;
   assign rsp.plain_byte    = plain_ff;
   assign rsp.modulus_error = err_ff;
endmodule

// ===== hw/rtl/rsa64_modmul.sv =====
`timescale 1ns / 1ps

// Bit-serial modular multiplier: one bit of b per cycle, a < m assumed.
// The multiplier b is always a full data word, so the same unit also reduces
// a full-width base by taking a = 1.
module rsa64_modmul #(
   parameter int KEY_BITS = rsa64_pkg::KEY_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [KEY_BITS-1:0]               a,
   input  logic [rsa64_pkg::DATA_WIDTH-1:0]  b,
   input  logic [KEY_BITS-1:0]               m,
   output logic [KEY_BITS-1:0]               result,
   output rsa64_pkg::mm_ctrl_type            status
);
   localparam int DW = rsa64_pkg::DATA_WIDTH;
   localparam int CW = $clog2(DW);

   logic [KEY_BITS-1:0] acc_ff, acc_in;
   logic [DW-1:0]       b_ff, b_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                start_ff;

   logic [KEY_BITS:0]   dbl, dbl_red, sum;
   logic [KEY_BITS-1:0] stage1;

   always_comb begin
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
      stage1  = dbl_red[KEY_BITS-1:0];
      sum     = {1'b0, stage1} + {1'b0, a};
      if (b_ff[DW-1] && (sum >= {1'b0, m})) begin
         sum = sum - {1'b0, m};
      end
      acc_in  = acc_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         acc_in  = '0;
         b_in    = b;
         cnt_in  = CW'(DW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = b_ff[DW-1] ? sum[KEY_BITS-1:0] : stage1;
         b_in   = b_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      b_ff   <= b_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff  <= 1'b0;
         start_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         start_ff <= start;
      end
   end

   assign result       = acc_ff;
   assign status.busy  = busy_ff;
   assign status.start = start_ff;
endmodule

// ===== hw/rtl/rsa64_seq.sv =====
`timescale 1ns / 1ps

// Square-and-multiply sequencer around the shared modular multiplier.
module rsa64_seq #(
   parameter int KEY_BITS = rsa64_pkg::KEY_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             go,
   input  logic [rsa64_pkg::DATA_WIDTH-1:0] base,
   input  logic [KEY_BITS-1:0]              expo,
   input  logic [KEY_BITS-1:0]              m,
   output logic                             done,
   output logic [KEY_BITS-1:0]              value
);
   localparam int DW = rsa64_pkg::DATA_WIDTH;
   localparam int CW = $clog2(KEY_BITS);

   rsa64_pkg::state_type state_ff, state_in;
   logic [KEY_BITS-1:0] r_ff, r_in;
   logic [DW-1:0]       b_ff, b_in;
   logic [KEY_BITS-1:0] e_ff, e_in;
   logic [CW-1:0]       bit_ff, bit_in;
   logic                issued_ff, issued_in;

   logic                mm_start;
   logic [KEY_BITS-1:0] mm_a, mm_res;
   logic [DW-1:0]       mm_b;
   rsa64_pkg::mm_ctrl_type mm_st;

   rsa64_modmul #(.KEY_BITS(KEY_BITS)) u_mm (
      .clock(clock), .reset(reset), .start(mm_start), .a(mm_a), .b(mm_b),
      .m(m), .result(mm_res), .status(mm_st)
   );

   logic mm_fin;
   assign mm_fin = issued_ff && !mm_st.busy && !mm_st.start;

   always_comb begin
      state_in  = state_ff;
      r_in      = r_ff;
      b_in      = b_ff;
      e_in      = e_ff;
      bit_in    = bit_ff;
      issued_in = issued_ff;
      mm_start  = 1'b0;
      mm_a      = r_ff;
      mm_b      = DW'(r_ff);
      done      = 1'b0;
      case (state_ff)
         rsa64_pkg::ST_IDLE: begin
            if (go) begin
               b_in      = base;
               e_in      = expo;
               r_in      = KEY_BITS'(1);
               bit_in    = CW'(KEY_BITS - 1);
               issued_in = 1'b0;
               state_in  = rsa64_pkg::ST_REDUCE;
            end
         end
         rsa64_pkg::ST_REDUCE: begin
            // base mod m as base*1 mod m is invalid for base >= m; reduce by
            // the multiplier with a = 1 and b = base instead.
            mm_a = KEY_BITS'(1);
            mm_b = b_ff;
            if (!issued_ff) begin
               mm_start  = 1'b1;
               issued_in = 1'b1;
            end else if (mm_fin) begin
               b_in      = DW'(mm_res);
               issued_in = 1'b0;
               state_in  = rsa64_pkg::ST_SQUARE;
            end
         end
         rsa64_pkg::ST_SQUARE: begin
            if (!issued_ff) begin
               mm_start  = 1'b1;
               issued_in = 1'b1;
            end else if (mm_fin) begin
               r_in      = mm_res;
               issued_in = 1'b0;
               if (e_ff[KEY_BITS-1]) begin
                  state_in = rsa64_pkg::ST_MULT;
               end else if (bit_ff == '0) begin
                  state_in = rsa64_pkg::ST_DONE;
               end else begin
                  bit_in = bit_ff - 1'b1;
                  e_in   = e_ff << 1;
               end
            end
         end
         rsa64_pkg::ST_MULT: begin
            mm_a = b_ff[KEY_BITS-1:0];
            mm_b = DW'(r_ff);
            if (!issued_ff) begin
               mm_start  = 1'b1;
               issued_in = 1'b1;
            end else if (mm_fin) begin
               r_in      = mm_res;
               issued_in = 1'b0;
               if (bit_ff == '0) begin
                  state_in = rsa64_pkg::ST_DONE;
               end else begin
                  bit_in   = bit_ff - 1'b1;
                  e_in     = e_ff << 1;
                  state_in = rsa64_pkg::ST_SQUARE;
               end
            end
         end
         rsa64_pkg::ST_DONE: begin
            done     = 1'b1;
            state_in = rsa64_pkg::ST_IDLE;
         end
         default: state_in = rsa64_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      r_ff   <= r_in;
      b_ff   <= b_in;
      e_ff   <= e_in;
      bit_ff <= bit_in;
      if (reset) begin
         state_ff  <= rsa64_pkg::ST_IDLE;
         issued_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         issued_ff <= issued_in;
      end
   end

   assign value = r_ff;
endmodule
